>>> src/srl_pkg.sv
// shared types and constants of the scroll region line remap block
package srl_pkg;

  localparam int DEPTH_DEF = 64;

  localparam int KIND_W   = 2;
  localparam int LINE_W   = 6;
  localparam int REGION_W = 7;
  localparam int SLOT_W   = 6;
  localparam int ADDR_W   = 32;
  localparam int STATUS_W = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int LBYTES_W = 16;

  localparam logic [KIND_W-1:0] KIND_LOOKUP    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ROLL_UP   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ROLL_DOWN = 2'd2;

  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_SKIP  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_BYTES   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_LINES = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [LINE_W-1:0]   line_index;
    logic [REGION_W-1:0] region_begin;
    logic [REGION_W-1:0] region_end;
    logic [REGION_W-1:0] roll_count;
  } in_word_t;

  typedef struct packed {
    logic [SLOT_W-1:0]   slot_number;
    logic [ADDR_W-1:0]   slot_address;
    logic [STATUS_W-1:0] status;
  } out_word_t;

  // control broadcast from the sequencer to every cell
  typedef struct packed {
    logic                shift;
    logic                up;
    logic [REGION_W-1:0] region_begin;
    logic [REGION_W-1:0] region_end;
    logic [REGION_W-1:0] tap_sel;
  } cell_ctrl_t;

endpackage

>>> src/srl_ifs.sv
// valid/ready channel interfaces for input and result words
interface srl_in_if import srl_pkg::*; ();
  logic     valid;
  logic     ready;
  in_word_t word;

  modport source (output valid, output word, input ready);
  modport sink (input valid, input word, output ready);
endinterface

interface srl_out_if import srl_pkg::*; ();
  logic      valid;
  logic      ready;
  out_word_t word;

  modport source (output valid, output word, input ready);
  modport sink (input valid, input word, output ready);
endinterface

>>> src/srl_cell.sv
// one table cell: holds one map entry and shifts with its neighbors
module srl_cell import srl_pkg::*; #(
  parameter int INDEX = 0,
  parameter int EW    = 6
) (
  input  logic          clk,
  input  logic          rst_n,
  input  cell_ctrl_t    ctrl,
  input  logic [EW-1:0] wrap_data,
  input  logic [EW-1:0] from_left,
  input  logic [EW-1:0] from_right,
  output logic [EW-1:0] entry,
  output logic [EW-1:0] tap
);

  localparam logic [8:0] IDX = 9'(INDEX);

  logic [EW-1:0] entry_r;
  logic [EW-1:0] entry_nxt;
  logic [8:0]    rb;
  logic [8:0]    re;
  logic          in_region;
  logic          wrap_up;
  logic          wrap_dn;

  assign rb        = {2'b00, ctrl.region_begin};
  assign re        = {2'b00, ctrl.region_end};
  assign in_region = (IDX >= rb) && (IDX < re);
  assign wrap_up   = (re == IDX + 9'd1);
  assign wrap_dn   = (rb == IDX);

  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.shift && in_region) begin
      if (ctrl.up) begin
        entry_nxt = wrap_up ? wrap_data : from_right;
      end else begin
        entry_nxt = wrap_dn ? wrap_data : from_left;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r <= EW'(INDEX);
    end else begin
      entry_r <= entry_nxt;
    end
  end

  assign entry = entry_r;
  assign tap   = (IDX == {2'b00, ctrl.tap_sel}) ? entry_r : '0;

endmodule

>>> src/scroll_region_line_remap.sv
// top level of the scroll region line remap table
// Maps logical screen lines to physical line slots through a row of DEPTH
// cells, one map entry per cell, identity after reset. One word is worked on
// at a time. A lookup registers the cell tap select, then the slot times line
// size product, then adds the base into the output register. A roll up or
// roll down moves the region one position per cycle, every cell of the region
// taking its neighbor's entry and the end cell (roll up) or begin cell (roll
// down) taking the wrapped entry, until roll_count steps are done. Skipped
// and out-of-range words and zero-count rolls go straight to the finish
// state. A new word can be accepted while a finished result still waits in
// the output register. Configuration writes go straight into the registers
// and the user must make them only while the block is idle; it is unchecked.
module scroll_region_line_remap import srl_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  srl_in_if.sink                in_chan,
  srl_out_if.source             out_chan
);

  localparam int EW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW = EW + LBYTES_W;
  localparam logic [8:0] DEPTH_W9 = 9'(DEPTH);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_LOOK = 5'b00010,
    S_MUL  = 5'b00100,
    S_ROLL = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  // configuration registers
  logic [ADDR_W-1:0]   base_r;
  logic [LBYTES_W-1:0] line_bytes_r;
  logic [REGION_W-1:0] active_r;

  // sequencer
  state_t              state_r, state_nxt;
  logic [STATUS_W-1:0] status_r;
  logic                look_r;
  logic                up_r;
  logic [REGION_W-1:0] begin_r;
  logic [REGION_W-1:0] end_r;
  logic [REGION_W-1:0] sel_r;
  logic [REGION_W-1:0] steps_r;
  logic [EW-1:0]       slot_r;
  logic [PW-1:0]       prod_r;

  // output register
  logic      out_valid_r;
  out_word_t out_word_r;

  // cell row
  cell_ctrl_t    ctrl;
  logic [EW-1:0] entry [DEPTH];
  logic [EW-1:0] tap   [DEPTH];
  logic [EW-1:0] tap_bus;

  // accept-time decode
  in_word_t            iw;
  logic                in_acc;
  logic                out_free;
  logic [8:0]          used9;
  logic [REGION_W-1:0] reg_len;
  logic [STATUS_W-1:0] acc_status;
  logic [EW+SLOT_W-1:0] slot_ext;

  assign iw       = in_chan.word;
  assign in_chan.ready = (state_r == S_IDLE);
  assign in_acc   = in_chan.valid && (state_r == S_IDLE);
  assign out_free = !out_valid_r || out_chan.ready;

  // lines in use, capped at the table depth
  assign used9   = ({2'b00, active_r} > DEPTH_W9) ? DEPTH_W9 : {2'b00, active_r};
  assign reg_len = iw.region_end - iw.region_begin;

  always_comb begin
    case (iw.kind)
      KIND_LOOKUP: begin
        acc_status = ({3'b000, iw.line_index} < used9) ? ST_DONE : ST_RANGE;
      end
      KIND_ROLL_UP, KIND_ROLL_DOWN: begin
        if ((iw.region_begin > iw.region_end) || ({2'b00, iw.region_end} > used9)) begin
          acc_status = ST_RANGE;
        end else if (iw.roll_count >= reg_len) begin
          // empty region lands here too
          acc_status = ST_SKIP;
        end else begin
          acc_status = ST_DONE;
        end
      end
      default: begin
        acc_status = ST_RANGE;
      end
    endcase
  end

  // config write port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r       <= '0;
      line_bytes_r <= 16'd128;
      active_r     <= 7'd64;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BASE_ADDRESS: base_r       <= cfg_wdata;
        CFG_LINE_BYTES:   line_bytes_r <= cfg_wdata[LBYTES_W-1:0];
        CFG_ACTIVE_LINES: active_r     <= cfg_wdata[REGION_W-1:0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (acc_status != ST_DONE) begin
            state_nxt = S_FIN;
          end else if (iw.kind == KIND_LOOKUP) begin
            state_nxt = S_LOOK;
          end else if (iw.roll_count == '0) begin
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_ROLL;
          end
        end
      end
      S_LOOK: state_nxt = S_MUL;
      S_MUL:  state_nxt = S_FIN;
      S_ROLL: begin
        if (steps_r == 7'd1) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // per-word working registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      status_r <= acc_status;
      look_r   <= (iw.kind == KIND_LOOKUP);
      up_r     <= (iw.kind == KIND_ROLL_UP);
      begin_r  <= iw.region_begin;
      end_r    <= iw.region_end;
      steps_r  <= iw.roll_count;
      // wrap source: region head for roll up, region tail for roll down
      if (iw.kind == KIND_LOOKUP) begin
        sel_r <= {1'b0, iw.line_index};
      end else if (iw.kind == KIND_ROLL_UP) begin
        sel_r <= iw.region_begin;
      end else begin
        sel_r <= iw.region_end - 7'd1;
      end
    end else if (state_r == S_ROLL) begin
      steps_r <= steps_r - 7'd1;
    end
    if (state_r == S_LOOK) begin
      slot_r <= tap_bus;
    end
    if (state_r == S_MUL) begin
      prod_r <= PW'(slot_r * line_bytes_r);
    end
  end

  // cell row control
  always_comb begin
    ctrl.shift        = (state_r == S_ROLL);
    ctrl.up           = up_r;
    ctrl.region_begin = begin_r;
    ctrl.region_end   = end_r;
    ctrl.tap_sel      = sel_r;
  end

  // one-hot tap reduction across the row
  always_comb begin
    tap_bus = '0;
    for (int i = 0; i < DEPTH; i++) begin
      tap_bus = tap_bus | tap[i];
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [EW-1:0] left_d;
    logic [EW-1:0] right_d;
    if (g == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_mid_l
      assign left_d = entry[g-1];
    end
    if (g == DEPTH-1) begin : g_last
      assign right_d = '0;
    end else begin : g_mid_r
      assign right_d = entry[g+1];
    end
    srl_cell #(
      .INDEX (g),
      .EW    (EW)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .wrap_data  (tap_bus),
      .from_left  (left_d),
      .from_right (right_d),
      .entry      (entry[g]),
      .tap        (tap[g])
    );
  end

  // wide tables report the low bits of the slot
  assign slot_ext = {{SLOT_W{1'b0}}, slot_r};

  // output register, loaded when the result is free to go
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_FIN && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_FIN && out_free) begin
      out_word_r.status <= status_r;
      if (look_r && status_r == ST_DONE) begin
        out_word_r.slot_number  <= slot_ext[SLOT_W-1:0];
        out_word_r.slot_address <= base_r + ADDR_W'(prod_r);
      end else begin
        out_word_r.slot_number  <= '0;
        out_word_r.slot_address <= '0;
      end
    end
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.word  = out_word_r;

  // rotate steps run only for a valid rotate with steps left
  a_roll_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROLL) |-> (status_r == ST_DONE && steps_r != '0 && !look_r))
    else $error("rotate step without a valid rotate");

  // an accepted word always leaves idle
  a_acc_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=> (state_r != S_IDLE))
    else $error("accepted word did not start work");

  // finishing with room in the output register presents a result
  a_fin_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && out_free) |=> (out_valid_r && state_r == S_IDLE))
    else $error("finished word not presented");

endmodule

>>> dv/scroll_region_line_remap_test.sv
// self-checking testbench for the scroll region line remap table
module scroll_region_line_remap_test;
  timeunit 1ns;
  timeprecision 1ps;
  import srl_pkg::*;

  localparam int TABLE_DEPTH = DEPTH_DEF;
  // kind code that names no operation
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  // long receiver hold-off, so the block backs up into its input
  localparam int CHOKE_CYCLES  = 300;
  // cycles with no handshake on either side before giving up
  localparam int STALL_LIMIT   = 3000;
  // longest rotate is 63 steps plus the pipeline states
  localparam int SETTLE_CYCLES = 80;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  srl_in_if  in_if ();
  srl_out_if out_if ();

  scroll_region_line_remap #(.DEPTH(TABLE_DEPTH)) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_chan   (in_if),
    .out_chan  (out_if)
  );

  always #5 clk = ~clk;

  // mirror of the remap table and the registers
  logic [SLOT_W-1:0]   line_map [TABLE_DEPTH];
  logic [ADDR_W-1:0]   base_addr;
  logic [LBYTES_W-1:0] bytes_per_line;
  logic [REGION_W-1:0] act_lines;

  in_word_t  words_to_send [$];   // words waiting for the driver
  out_word_t answers_due [$];     // predicted result words, oldest first
  out_word_t want;

  bit idling_on;                  // random gaps on both channels
  bit choke_request;              // asks the monitor for one long hold-off
  int send_gap;
  int hold_left;
  int failures;
  int quiet_cycles;

  // lines in use: active_lines capped at the table depth, zero means none
  function automatic int unsigned lines_used();
    return (act_lines > TABLE_DEPTH) ? TABLE_DEPTH : act_lines;
  endfunction

  // applies one word to the mirror and returns the result word it must give
  function automatic out_word_t apply_remap_word(in_word_t w);
    out_word_t         ans;
    logic [SLOT_W-1:0] moved [TABLE_DEPTH];
    int unsigned       used, first, stop, len, shift;
    ans   = '0;
    used  = lines_used();
    first = w.region_begin;
    stop  = w.region_end;
    case (w.kind)
      KIND_LOOKUP: begin
        if (w.line_index < used) begin
          ans.slot_number  = line_map[w.line_index];
          // slot times line size, wrapped to the address width
          ans.slot_address = base_addr + ADDR_W'(line_map[w.line_index]) * ADDR_W'(bytes_per_line);
        end else begin
          ans.status = ST_RANGE;
        end
      end
      KIND_ROLL_UP, KIND_ROLL_DOWN: begin
        if (first > stop || stop > used) begin
          ans.status = ST_RANGE;
        end else if (w.roll_count >= stop - first) begin
          // covers the empty region too
          ans.status = ST_SKIP;
        end else begin
          len = stop - first;
          // rolling up by n equals rolling down by len - n
          shift = (w.kind == KIND_ROLL_UP) ? len - w.roll_count : w.roll_count;
          for (int j = 0; j < len; j++) moved[(j + shift) % len] = line_map[first + j];
          for (int j = 0; j < len; j++) line_map[first + j] = moved[j];
        end
      end
      default: begin
        ans.status = ST_RANGE;
      end
    endcase
    return ans;
  endfunction

  function automatic in_word_t make_word(logic [KIND_W-1:0] kind, int unsigned idx,
                                         int unsigned first, int unsigned stop,
                                         int unsigned count);
    in_word_t w;
    w.kind         = kind;
    w.line_index   = LINE_W'(idx);
    w.region_begin = REGION_W'(first);
    w.region_end   = REGION_W'(stop);
    w.roll_count   = REGION_W'(count);
    return w;
  endfunction

  // mostly well-formed lookups and rolls, the rest malformed on purpose
  function automatic in_word_t random_word();
    in_word_t    w;
    int unsigned used, pick, first, stop, len, top;
    used = lines_used();
    // unused fields carry random bits
    w    = make_word(KIND_LOOKUP, $urandom, $urandom, $urandom, $urandom);
    pick = $urandom_range(0, 99);
    first = 0;
    stop  = 0;
    if (used > 0) begin
      if ($urandom_range(0, 7) == 0) begin
        stop = used;
      end else begin
        first = $urandom_range(0, used - 1);
        stop  = $urandom_range(first + 1, used);
      end
    end
    len = stop - first;
    if (pick < 45) begin
      if (used > 0) w.line_index = LINE_W'($urandom_range(0, used - 1));
    end else if (pick < 85) begin
      w.kind         = $urandom_range(0, 1) ? KIND_ROLL_UP : KIND_ROLL_DOWN;
      w.region_begin = REGION_W'(first);
      w.region_end   = REGION_W'(stop);
      if (len > 0) begin
        // short rolls mostly, now and then anything below the length
        top = (len - 1 < 4) ? len - 1 : 4;
        if ($urandom_range(0, 3) == 0) top = len - 1;
        w.roll_count = REGION_W'($urandom_range(0, top));
      end
    end else begin
      case ($urandom_range(0, 5))
        0: w.kind = KIND_UNUSED;
        1: begin
          // lookup past the lines in use
          if (used < TABLE_DEPTH) w.line_index = LINE_W'($urandom_range(used, TABLE_DEPTH - 1));
        end
        2: begin
          // region begins after it ends
          w.kind         = KIND_ROLL_DOWN;
          stop           = $urandom_range(0, 126);
          w.region_end   = REGION_W'(stop);
          w.region_begin = REGION_W'($urandom_range(stop + 1, 127));
        end
        3: begin
          // region reaches past the lines in use
          w.kind         = KIND_ROLL_UP;
          stop           = $urandom_range(used + 1, 127);
          w.region_end   = REGION_W'(stop);
          w.region_begin = REGION_W'($urandom_range(0, stop));
        end
        4: begin
          // count at least the region length
          w.kind         = $urandom_range(0, 1) ? KIND_ROLL_UP : KIND_ROLL_DOWN;
          w.region_begin = REGION_W'(first);
          w.region_end   = REGION_W'(stop);
          w.roll_count   = REGION_W'($urandom_range(len, 127));
        end
        default: w.kind = KIND_W'($urandom);
      endcase
    end
    return w;
  endfunction

  // gap length: mostly none or short, a few long
  function automatic int pick_gap();
    int unsigned r;
    if (!idling_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // one register write, the mirror follows once it is done
  task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (index)
      CFG_BASE_ADDRESS: base_addr      = value;
      CFG_LINE_BYTES:   bytes_per_line = value[LBYTES_W-1:0];
      CFG_ACTIVE_LINES: act_lines      = value[REGION_W-1:0];
      default: ;
    endcase
  endtask

  task automatic configure(logic [CFG_DATA_W-1:0] base, logic [CFG_DATA_W-1:0] lbytes,
                           logic [CFG_DATA_W-1:0] active);
    write_reg(CFG_BASE_ADDRESS, base);
    write_reg(CFG_LINE_BYTES, lbytes);
    write_reg(CFG_ACTIVE_LINES, active);
  endtask

  // every queued word sent and every result word back
  task automatic wait_idle();
    while (words_to_send.size() != 0 || in_if.valid || answers_due.size() != 0)
      @(negedge clk);
  endtask

  task automatic run_phase(int unsigned count);
    @(negedge clk);
    repeat (count) words_to_send.push_back(random_word());
    wait_idle();
  endtask

  // driver: offers queued words, predicts each one at acceptance
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      in_if.word  <= '0;
      send_gap = 0;
    end else begin
      if (in_if.valid && in_if.ready) answers_due.push_back(apply_remap_word(in_if.word));
      // a word on the channel stays put until taken
      if (!in_if.valid || in_if.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_if.valid <= 1'b0;
        end else if (words_to_send.size() > 0) begin
          in_if.word  <= words_to_send.pop_front();
          in_if.valid <= 1'b1;
          send_gap = pick_gap();
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each result word against the oldest prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      hold_left = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (answers_due.size() == 0) begin
          $error("result word with nothing expected: slot_number %0d slot_address %h status %0d",
                 out_if.word.slot_number, out_if.word.slot_address, out_if.word.status);
          failures++;
        end else begin
          want = answers_due.pop_front();
          if (out_if.word.slot_number !== want.slot_number) begin
            $error("slot_number: expected %0d, got %0d", want.slot_number,
                   out_if.word.slot_number);
            failures++;
          end
          if (out_if.word.slot_address !== want.slot_address) begin
            $error("slot_address: expected %h, got %h", want.slot_address,
                   out_if.word.slot_address);
            failures++;
          end
          if (out_if.word.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_if.word.status);
            failures++;
          end
        end
      end
      // ready pattern: long hold-off on request, else random pauses
      if (choke_request) begin
        choke_request = 1'b0;
        hold_left = CHOKE_CYCLES;
        out_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        hold_left = pick_gap();
        out_if.ready <= (hold_left == 0);
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("scroll_region_line_remap test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    in_if.valid  = 1'b0;
    in_if.word   = '0;
    out_if.ready = 1'b0;
    // state after reset: identity map, default registers
    for (int i = 0; i < TABLE_DEPTH; i++) line_map[i] = SLOT_W'(i);
    base_addr      = '0;
    bytes_per_line = LBYTES_W'(128);
    act_lines      = REGION_W'(64);
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed words at the reset settings, no idling
    @(negedge clk);
    words_to_send.push_back(make_word(KIND_LOOKUP, 0, 0, 0, 0));
    words_to_send.push_back(make_word(KIND_LOOKUP, 63, 127, 127, 127));
    words_to_send.push_back(make_word(KIND_ROLL_UP, 0, 0, 64, 1));
    words_to_send.push_back(make_word(KIND_LOOKUP, 0, 0, 0, 0));
    words_to_send.push_back(make_word(KIND_LOOKUP, 63, 0, 0, 0));
    words_to_send.push_back(make_word(KIND_ROLL_DOWN, 0, 0, 64, 63));
    words_to_send.push_back(make_word(KIND_LOOKUP, 0, 0, 0, 0));
    // zero count: full turn, nothing moves
    words_to_send.push_back(make_word(KIND_ROLL_UP, 0, 10, 20, 0));
    // empty region and counts reaching the length are skipped
    words_to_send.push_back(make_word(KIND_ROLL_DOWN, 0, 5, 5, 0));
    words_to_send.push_back(make_word(KIND_ROLL_UP, 0, 3, 8, 5));
    words_to_send.push_back(make_word(KIND_ROLL_DOWN, 0, 3, 8, 127));
    // malformed regions and the unused kind
    words_to_send.push_back(make_word(KIND_ROLL_DOWN, 0, 127, 64, 1));
    words_to_send.push_back(make_word(KIND_ROLL_UP, 0, 0, 65, 1));
    words_to_send.push_back(make_word(KIND_ROLL_UP, 0, 9, 8, 0));
    words_to_send.push_back(make_word(KIND_UNUSED, 63, 127, 127, 127));
    words_to_send.push_back(make_word(KIND_ROLL_UP, 0, 0, 2, 1));
    words_to_send.push_back(make_word(KIND_LOOKUP, 0, 0, 0, 0));
    words_to_send.push_back(make_word(KIND_ROLL_DOWN, 0, 62, 64, 1));
    words_to_send.push_back(make_word(KIND_LOOKUP, 63, 0, 0, 0));
    wait_idle();

    // zero line size and an active count above the depth
    configure(32'hFFFF_FFFF, 32'd0, 32'd100);
    @(negedge clk);
    words_to_send.push_back(make_word(KIND_LOOKUP, 63, 0, 0, 0));
    words_to_send.push_back(make_word(KIND_ROLL_UP, 0, 0, 64, 3));
    words_to_send.push_back(make_word(KIND_ROLL_UP, 0, 0, 65, 0));
    wait_idle();

    // no lines in use at all
    write_reg(CFG_ACTIVE_LINES, 32'd0);
    @(negedge clk);
    words_to_send.push_back(make_word(KIND_LOOKUP, 0, 0, 0, 0));
    words_to_send.push_back(make_word(KIND_ROLL_DOWN, 0, 0, 0, 0));
    words_to_send.push_back(make_word(KIND_ROLL_UP, 0, 0, 1, 0));
    wait_idle();

    // random phases over a spread of settings
    idling_on = 1'b1;
    configure(32'hFFFF_FFFF, 32'h0000_FFFF, 32'd64);
    run_phase(250);

    idling_on = 1'b0;
    configure($urandom, 32'd1, 32'd1);
    run_phase(120);

    idling_on = 1'b1;
    configure(32'h8000_0000, 32'd0, 32'd100);
    run_phase(200);

    configure($urandom, $urandom_range(1, 65535), 32'd0);
    run_phase(40);

    // block fills up while the receiver holds off
    configure($urandom, $urandom_range(1, 65535), $urandom_range(2, 63));
    @(negedge clk);
    choke_request = 1'b1;
    run_phase(300);

    // junk above the register widths must be dropped
    configure($urandom, {16'($urandom), 16'($urandom_range(1, 65535))},
              {25'($urandom), 7'd64});
    run_phase(340);

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (failures == 0 && answers_due.size() == 0) begin
      $display("scroll_region_line_remap test passed");
    end else begin
      $display("scroll_region_line_remap test failed");
    end
    $finish;
  end

endmodule
